### hdl/utf8_to_utf32_padded_rows_defines.svh
// Assertion macros for the UTF-8 to UTF-32 row decoder checker.
// Macros expect clk and arst_n in the scope where they are used.
`ifndef UTF8_TO_UTF32_PADDED_ROWS_DEFINES_SVH
`define UTF8_TO_UTF32_PADDED_ROWS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define U2U_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u2u checker: property failed");

// Next-cycle implication, disabled during reset.
`define U2U_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u2u checker: property failed");

`endif

### hdl/u2u_pkg.sv
// Shared types and constants of the UTF-8 to UTF-32 row decoder.
// No dependencies; imported by every module of the block.
package u2u_pkg;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} utf8_item_t;

	typedef struct packed {
		logic [20:0] codepoint;
		logic [4:0]  slot_index;
		logic [15:0] row_index;
		logic        row_last;
		logic [16:0] error_row;
	} cp_item_t;

	// Controller to datapath
	typedef struct packed {
		logic take;   // input item accepted this cycle
		logic pad;    // emit one zero slot
		logic close;  // finish the row
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic room;       // row still has free slots
		logic out_valid;  // output register holds an item
	} dp_stat_t;

	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_LAST  = 2'd1;
	localparam logic [1:0] ACT_EMPTY = 2'd2;

	localparam logic [5:0] MAX_SLOTS    = 6'd32;
	localparam logic [5:0] MAX_CP_RESET = 6'd32;

	localparam logic REG_MAX_CP = 1'b0;

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_PAD = 1'b1;

endpackage

### hdl/u2u_regs.sv
// Configuration register file of the row decoder (APB-style write/read).
// Depends on u2u_pkg.
module u2u_regs import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [5:0]  row_width
);

	logic [5:0] max_cp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= MAX_CP_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_MAX_CP)) begin
			max_cp_q <= pwdata[5:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == REG_MAX_CP) begin
			prdata = {26'd0, max_cp_q};
		end
	end

	// Clamp the row to the slot limit
	assign row_width = (max_cp_q > MAX_SLOTS) ? MAX_SLOTS : max_cp_q;

endmodule

### hdl/u2u_ctrl.sv
// Controller of the row decoder: input handshake and row padding sequence.
// Depends on u2u_pkg; drives the datapath through dp_cmd_t.
module u2u_ctrl import u2u_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     utf8_valid,
	input  logic     closes_row,
	input  logic     cp_ready,
	input  dp_stat_t stat,
	output logic     utf8_ready,
	output dp_cmd_t  cmd
);

	logic state_q;
	logic state_d;
	logic out_free;

	assign out_free = !stat.out_valid || cp_ready;

	always_comb begin
		state_d    = state_q;
		utf8_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_RUN: begin
				utf8_ready = out_free;
				cmd.take   = utf8_valid && out_free;
				if (utf8_valid && out_free && closes_row) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				// pad one slot per free output cycle, then close the row
				if (out_free) begin
					if (stat.room) begin
						cmd.pad = 1'b1;
					end else begin
						cmd.close = 1'b1;
						state_d   = ST_RUN;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/u2u_dp.sv
// Datapath of the row decoder: UTF-8 assembly, row state, output register.
// Depends on u2u_pkg; controlled by u2u_ctrl through dp_cmd_t.
module u2u_dp import u2u_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  utf8_item_t utf8_item,
	input  logic [5:0] row_width,
	input  logic       cp_ready,
	output dp_stat_t   stat,
	output logic       cp_valid,
	output cp_item_t   cp_item
);

	logic [20:0] acc_q;
	logic [1:0]  pend_q;
	logic [5:0]  filled_q;
	logic        stopped_q;
	logic [15:0] row_q;
	logic [16:0] err_q;
	logic        out_valid_q;
	cp_item_t    out_item_q;

	logic [20:0] acc_d;
	logic [1:0]  pend_d;
	logic        stop_d;
	logic [16:0] err_d;
	logic        emit;
	logic [20:0] emit_val;
	logic        room;
	logic        load;
	logic [16:0] cand;
	logic [7:0]  b;

	assign b    = utf8_item.data_byte;
	assign room = filled_q < row_width;
	assign cand = {1'b0, row_q} + 17'd1;

	always_comb begin
		acc_d    = acc_q;
		pend_d   = pend_q;
		stop_d   = stopped_q;
		err_d    = err_q;
		emit     = 1'b0;
		emit_val = '0;
		if (cmd.take && !utf8_item.action[1] && !stopped_q) begin
			if (pend_q != 2'd0) begin
				// continuation: append low six bits, no check
				acc_d  = {acc_q[14:0], b[5:0]};
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					emit     = 1'b1;
					emit_val = {acc_q[14:0], b[5:0]};
				end
			end else if (b[7] == 1'b0) begin
				emit     = 1'b1;
				emit_val = {14'd0, b[6:0]};
			end else if (b[7:5] == 3'b110) begin
				acc_d  = {16'd0, b[4:0]};
				pend_d = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				acc_d  = {17'd0, b[3:0]};
				pend_d = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				acc_d  = {18'd0, b[2:0]};
				pend_d = 2'd3;
			end else begin
				// invalid lead: stop the sublist, keep the largest error
				stop_d = 1'b1;
				if (cand > err_q) begin
					err_d = cand;
				end
			end
		end
	end

	// Drop codepoints past the row width
	assign load = (emit && room) || cmd.pad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pend_q    <= '0;
			filled_q  <= '0;
			stopped_q <= 1'b0;
			row_q     <= '0;
			err_q     <= '0;
		end else begin
			err_q <= err_d;
			if (cmd.close) begin
				acc_q     <= '0;
				pend_q    <= '0;
				filled_q  <= '0;
				stopped_q <= 1'b0;
				row_q     <= row_q + 16'd1;
			end else begin
				acc_q     <= acc_d;
				pend_q    <= pend_d;
				stopped_q <= stop_d;
				if (load) begin
					filled_q <= filled_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (cp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q.codepoint  <= cmd.pad ? 21'd0 : emit_val;
			out_item_q.slot_index <= filled_q[4:0];
			out_item_q.row_index  <= row_q;
			out_item_q.row_last   <= (filled_q + 6'd1) == row_width;
			out_item_q.error_row  <= err_q;
		end
	end

	assign stat.room      = room;
	assign stat.out_valid = out_valid_q;
	assign cp_valid       = out_valid_q;
	assign cp_item        = out_item_q;

endmodule

### hdl/utf8_to_utf32_padded_rows.sv
// Usage
// Input channel utf8_valid/utf8_ready/utf8_item carries one UTF-8 byte per item,
// tagged as a byte inside a sublist, the last byte of a sublist, or an empty
// sublist. Output channel cp_valid/cp_ready/cp_item carries one row slot per
// item: a decoded codepoint or a zero padding slot, with its slot and row index.
// A completed codepoint is loaded into the output register when its last byte
// is accepted, unless the row is already full.
// Throughput: one byte item per cycle while the output is taken each cycle.
// An item that closes a sublist starts the padding sequence: the padding sequencer
// emits one slot per cycle through the single output register while it is free,
// then closes the row once the row is full; input ready stays low meanwhile.
// Reset clears the row and error state and sets max_codepoints to 32.
// When the receiver stalls, the output item holds and input ready stays low
// for as long as the occupied output register is not taken.
// APB register 0 (byte address 0) holds max_codepoints; write it only idle.
// Depends on u2u_pkg, u2u_regs, u2u_ctrl and u2u_dp.
module utf8_to_utf32_padded_rows import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        utf8_valid,
	output logic        utf8_ready,
	input  utf8_item_t  utf8_item,
	output logic        cp_valid,
	input  logic        cp_ready,
	output cp_item_t    cp_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [5:0] row_width;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic       closes_row;

	assign pready     = 1'b1;
	assign closes_row = utf8_item.action != ACT_BYTE;

	u2u_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.row_width (row_width)
	);

	u2u_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf8_valid (utf8_valid),
		.closes_row (closes_row),
		.cp_ready   (cp_ready),
		.stat       (stat),
		.utf8_ready (utf8_ready),
		.cmd        (cmd)
	);

	u2u_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.utf8_item (utf8_item),
		.row_width (row_width),
		.cp_ready  (cp_ready),
		.stat      (stat),
		.cp_valid  (cp_valid),
		.cp_item   (cp_item)
	);

endmodule

### hdl/u2u_checker.sv
// Port-level checker of the row decoder, bound to the top level.
// Depends on u2u_pkg and the assertion macros header.
`include "utf8_to_utf32_padded_rows_defines.svh"

module u2u_checker import u2u_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       utf8_valid,
	input logic       utf8_ready,
	input utf8_item_t utf8_item,
	input logic       cp_valid,
	input logic       cp_ready,
	input cp_item_t   cp_item
);

	// A stalled output item holds
	`U2U_ASSERT_NXT(a_out_hold, cp_valid && !cp_ready, cp_valid && $stable(cp_item))

	// Input is taken only when the output register can take a result
	`U2U_ASSERT_IMP(a_ready_needs_room, utf8_ready, !cp_valid || cp_ready)

	// While padding, a taken slot that is not the last one is followed at once
	`U2U_ASSERT_NXT(a_pad_burst, cp_valid && cp_ready && !utf8_ready && !cp_item.row_last,
		cp_valid)

endmodule

bind utf8_to_utf32_padded_rows u2u_checker u_u2u_checker (.*);

### verif/utf8_to_utf32_padded_rows_checker.sv
// Checker for the UTF-8 to UTF-32 row decoder: watches both channels and the APB port,
// predicts every row slot and compares it field by field with what the block emits.
// Depends on u2u_pkg.
module utf8_to_utf32_padded_rows_checker import u2u_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        utf8_valid,
	input  logic        utf8_ready,
	input  utf8_item_t  utf8_item,
	input  logic        cp_valid,
	input  logic        cp_ready,
	input  cp_item_t    cp_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          slots_owed
);

	logic [5:0]  max_cp;
	logic [20:0] partial_cp;
	logic [1:0]  cont_left;
	logic [5:0]  fill;
	logic        stopped;
	logic [15:0] row_num;
	logic [16:0] worst_err;
	cp_item_t    slot_q[$];

	function automatic logic [5:0] slots_per_row();
		return (max_cp > MAX_SLOTS) ? MAX_SLOTS : max_cp;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got_v,
			input int unsigned want_v);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
		fail_count++;
	endtask

	// Drop the slot once the row is full; decoding itself goes on.
	task automatic emit_slot(input logic [20:0] value);
		cp_item_t s;
		if (fill >= slots_per_row())
			return;
		s.codepoint  = value;
		s.slot_index = fill[4:0];
		s.row_index  = row_num;
		s.row_last   = (fill + 6'd1 == slots_per_row());
		s.error_row  = worst_err;
		slot_q.push_back(s);
		fill = fill + 6'd1;
	endtask

	// Pad the row with zero slots, then start the next sublist clean.
	task automatic finish_row();
		while (fill < slots_per_row())
			emit_slot(21'd0);
		row_num    = row_num + 16'd1;
		partial_cp = '0;
		cont_left  = '0;
		fill       = '0;
		stopped    = 1'b0;
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [16:0] cand;
		if (stopped)
			return;
		if (cont_left != 2'd0) begin
			partial_cp = {partial_cp[14:0], b[5:0]};
			cont_left  = cont_left - 2'd1;
			if (cont_left == 2'd0)
				emit_slot(partial_cp);
			return;
		end
		casez (b)
			8'b0???????: emit_slot({14'd0, b[6:0]});
			8'b110?????: begin
				partial_cp = {16'd0, b[4:0]};
				cont_left  = 2'd1;
			end
			8'b1110????: begin
				partial_cp = {17'd0, b[3:0]};
				cont_left  = 2'd2;
			end
			8'b11110???: begin
				partial_cp = {18'd0, b[2:0]};
				cont_left  = 2'd3;
			end
			default: begin
				stopped = 1'b1;
				cand = {1'b0, row_num} + 17'd1;
				if (cand > worst_err)
					worst_err = cand;
			end
		endcase
	endtask

	task automatic predict_slots(input utf8_item_t it);
		if (it.action == ACT_BYTE || it.action == ACT_LAST) begin
			decode_byte(it.data_byte);
			if (it.action == ACT_LAST)
				finish_row();
		end else begin
			finish_row();
		end
	endtask

	task automatic check_slot(input cp_item_t got);
		cp_item_t want;
		if (slot_q.size() == 0) begin
			report_mismatch("slot with none expected, codepoint", 32'(got.codepoint), 0);
			return;
		end
		want = slot_q.pop_front();
		if (got.codepoint !== want.codepoint)
			report_mismatch("codepoint", 32'(got.codepoint), 32'(want.codepoint));
		if (got.slot_index !== want.slot_index)
			report_mismatch("slot_index", 32'(got.slot_index), 32'(want.slot_index));
		if (got.row_index !== want.row_index)
			report_mismatch("row_index", 32'(got.row_index), 32'(want.row_index));
		if (got.row_last !== want.row_last)
			report_mismatch("row_last", 32'(got.row_last), 32'(want.row_last));
		if (got.error_row !== want.error_row)
			report_mismatch("error_row", 32'(got.error_row), 32'(want.error_row));
	endtask

	// Outputs of this edge come from earlier items, so check before predicting.
	always @(posedge clk) begin
		if (!arst_n) begin
			max_cp     = MAX_CP_RESET;
			partial_cp = '0;
			cont_left  = '0;
			fill       = '0;
			stopped    = 1'b0;
			row_num    = '0;
			worst_err  = '0;
			fail_count = 0;
			slot_q.delete();
			slots_owed <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_MAX_CP)
				max_cp = pwdata[5:0];
			if (cp_valid && cp_ready)
				check_slot(cp_item);
			if (utf8_valid && utf8_ready)
				predict_slots(utf8_item);
			slots_owed <= slot_q.size();
		end
	end

endmodule

### verif/utf8_to_utf32_padded_rows_tb.sv
// Top of the UTF-8 to UTF-32 row decoder testbench: clock, reset, byte and APB stimulus,
// random receiver stalls and the verdict. Depends on u2u_pkg, the block and its checker.
module utf8_to_utf32_padded_rows_tb;
	import u2u_pkg::*;

	// Reserved action code; the block treats it as an empty sublist.
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int PHASE_ITEMS = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        utf8_valid = 1'b0;
	logic        utf8_ready;
	utf8_item_t  utf8_item = '0;
	logic        cp_valid;
	logic        cp_ready = 1'b1;
	cp_item_t    cp_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic        paddr = REG_MAX_CP;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int slots_owed;
	int items_sent = 0;
	int gap_odds = 2;
	bit quiet = 1'b0;

	always #6 clk = ~clk;

	utf8_to_utf32_padded_rows u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf8_valid (utf8_valid),
		.utf8_ready (utf8_ready),
		.utf8_item  (utf8_item),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.cp_item    (cp_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	utf8_to_utf32_padded_rows_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf8_valid (utf8_valid),
		.utf8_ready (utf8_ready),
		.utf8_item  (utf8_item),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.cp_item    (cp_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.slots_owed (slots_owed)
	);

	// Hold valid across back-to-back items; lower it only for an idle burst.
	task automatic send_item(input logic [1:0] act, input logic [7:0] b);
		utf8_item_t it;
		it.action    = act;
		it.data_byte = b;
		if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
			utf8_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		utf8_valid <= 1'b1;
		utf8_item  <= it;
		@(posedge clk);
		while (!utf8_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Wait until every predicted slot has come out, then let the block settle.
	task automatic drain_rows();
		utf8_valid <= 1'b0;
		@(posedge clk);
		while (slots_owed != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Upper bits of the write data are don't-care; fill them with noise.
	task automatic set_row_width(input logic [5:0] w);
		logic [31:0] junk;
		junk = $urandom();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_MAX_CP;
		pwdata  <= {junk[31:6], w};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly well-formed sublists with random content, plus invalid leads,
	// stray continuation bits, truncated tails and empty sublists.
	task automatic send_sublist();
		logic [7:0] seq[$];
		logic [7:0] b;
		int n_cp;
		int len;
		int k;
		b = 8'($urandom());
		if ($urandom_range(0, 9) == 0) begin
			send_item($urandom_range(0, 1) ? ACT_EMPTY : ACT_SPARE, b);
			return;
		end
		n_cp = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
		for (k = 0; k < n_cp; k++) begin
			b = 8'($urandom());
			if ($urandom_range(0, 14) == 0) begin
				seq.push_back($urandom_range(0, 1) ? {2'b10, b[5:0]} : {5'b11111, b[2:0]});
			end else begin
				len = $urandom_range(1, 4);
				case (len)
					1: seq.push_back({1'b0, b[6:0]});
					2: seq.push_back({3'b110, b[4:0]});
					3: seq.push_back({4'b1110, b[3:0]});
					default: seq.push_back({5'b11110, b[2:0]});
				endcase
				for (int c = 1; c < len; c++) begin
					b = 8'($urandom());
					seq.push_back(($urandom_range(0, 9) == 0) ? b : {2'b10, b[5:0]});
				end
			end
		end
		if ($urandom_range(0, 7) == 0 && seq.size() > 1)
			void'(seq.pop_back());
		for (k = 0; k < seq.size(); k++)
			send_item((k == seq.size() - 1) ? ACT_LAST : ACT_BYTE, seq[k]);
	endtask

	// Receiver: random stall bursts until the quiet tail of the run.
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				cp_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			cp_ready <= 1'b1;
			repeat ($urandom_range(0, 20)) @(posedge clk);
		end
	end

	initial begin
		logic [5:0] widths[6];
		logic [7:0] b;
		int start;
		widths = '{6'd1, 6'd63, 6'd5, 6'd32, 6'd2, 6'd17};
		widths[5] = 6'($urandom_range(3, 31));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset width of 32: smallest and largest one-byte codepoints, smallest two-byte, largest three- and four-byte.
		send_item(ACT_BYTE, 8'h00);
		send_item(ACT_BYTE, 8'h7F);
		send_item(ACT_BYTE, 8'hC2);
		send_item(ACT_BYTE, 8'h80);
		send_item(ACT_BYTE, 8'hEF);
		send_item(ACT_BYTE, 8'hBF);
		send_item(ACT_BYTE, 8'hBF);
		send_item(ACT_BYTE, 8'hF7);
		send_item(ACT_BYTE, 8'hBF);
		send_item(ACT_BYTE, 8'hBF);
		send_item(ACT_LAST, 8'hBF);
		send_item(ACT_EMPTY, 8'hFF);
		send_item(ACT_SPARE, 8'h55);
		// Sequence cut short by the end of the sublist.
		send_item(ACT_BYTE, 8'hE2);
		send_item(ACT_LAST, 8'h82);
		// Invalid leads stop the sublist; the rest is ignored but still padded.
		send_item(ACT_BYTE, 8'h80);
		send_item(ACT_BYTE, 8'h41);
		send_item(ACT_LAST, 8'hC2);
		send_item(ACT_LAST, 8'hF8);
		// Continuation byte with the wrong top bits is only masked.
		send_item(ACT_BYTE, 8'hDF);
		send_item(ACT_LAST, 8'hFF);
		// Shrink the row to its current fill, then widen it in the middle of a row.
		send_item(ACT_BYTE, 8'h41);
		drain_rows();
		set_row_width(6'd1);
		send_item(ACT_LAST, 8'h41);
		send_item(ACT_BYTE, 8'h41);
		drain_rows();
		set_row_width(6'd5);
		send_item(ACT_LAST, 8'h41);

		foreach (widths[i]) begin
			drain_rows();
			set_row_width(widths[i]);
			gap_odds = $urandom_range(0, 3);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				send_sublist();
		end

		// Zero-width rows emit nothing.
		quiet = 1'b1;
		gap_odds = 0;
		drain_rows();
		set_row_width(6'd0);
		repeat (6) begin
			b = 8'($urandom());
			send_item(ACT_EMPTY, b);
		end
		drain_rows();
		set_row_width(6'd2);
		send_item(ACT_LAST, 8'h41);
		// A later invalid lead raises the error value above the earlier ones.
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_LAST, 8'h41);
		send_item(ACT_BYTE, 8'h41);
		send_item(ACT_LAST, 8'h42);
		send_item(ACT_EMPTY, 8'h00);
		drain_rows();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#18000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
